// File: src/link_error_recovery_policy_unit_defines.svh
// assertion macros for the link error recovery policy checker
// no dependencies; included by the checker file only
`ifndef LINK_ERROR_RECOVERY_POLICY_UNIT_DEFINES_SVH
`define LINK_ERROR_RECOVERY_POLICY_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LERP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lerp check failed");

// next-cycle implication, disabled during reset
`define LERP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lerp check failed");

`endif

// File: src/lerp_pkg.sv
// shared widths, codes, types and grading functions for the recovery policy unit
// no dependencies; used by the interfaces, the counter bank and the top level
package lerp_pkg;

	localparam int CHANNELS_DEF = 4;
	localparam int MASK_W       = 4;

	localparam int CMD_W   = 3;
	localparam int CHAN_W  = 3;
	localparam int CODE_W  = 4;
	localparam int RETRY_W = 8;
	localparam int ACT_W   = 3;
	localparam int SEL_W   = 3;
	localparam int SEV_W   = 3;
	localparam int DELAY_W = 16;
	localparam int CTR_W   = 32;
	localparam int CE_W    = 8;
	localparam int SRUN_W  = 4;
	localparam int NUM_CTRS = 8;

	localparam int REG_IDX_W  = 3;
	localparam int REG_DATA_W = 16;

	// commands
	localparam logic [CMD_W-1:0] CMD_REPORT   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SUCCESS  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_EXECUTE  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ     = 3'd4;
	localparam logic [CMD_W-1:0] CMD_LEAVE_FB = 3'd5;

	// error codes
	localparam logic [CODE_W-1:0] ERR_OK        = 4'd0;
	localparam logic [CODE_W-1:0] ERR_BUSY      = 4'd1;
	localparam logic [CODE_W-1:0] ERR_TIMEOUT   = 4'd2;
	localparam logic [CODE_W-1:0] ERR_NAK       = 4'd3;
	localparam logic [CODE_W-1:0] ERR_ARB_LOST  = 4'd4;
	localparam logic [CODE_W-1:0] ERR_DMA       = 4'd5;
	localparam logic [CODE_W-1:0] ERR_BAD_PARAM = 4'd6;
	localparam logic [CODE_W-1:0] ERR_NOT_INIT  = 4'd7;

	// severities
	localparam logic [SEV_W-1:0] SEV_INFO     = 3'd0;
	localparam logic [SEV_W-1:0] SEV_WARNING  = 3'd1;
	localparam logic [SEV_W-1:0] SEV_ERROR    = 3'd2;
	localparam logic [SEV_W-1:0] SEV_CRITICAL = 3'd3;
	localparam logic [SEV_W-1:0] SEV_FATAL    = 3'd4;

	// recovery actions
	localparam logic [ACT_W-1:0] ACT_NONE          = 3'd0;
	localparam logic [ACT_W-1:0] ACT_RETRY_NOW     = 3'd1;
	localparam logic [ACT_W-1:0] ACT_RETRY_DELAYED = 3'd2;
	localparam logic [ACT_W-1:0] ACT_FALLBACK      = 3'd3;
	localparam logic [ACT_W-1:0] ACT_RESET_PERIPH  = 3'd4;
	localparam logic [ACT_W-1:0] ACT_RESTART       = 3'd5;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_RETRY_LIMIT  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_DELAY_BASE   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DELAY_CAP    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ALLOW_FB     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ALLOW_PRESET = 3'd4;

	// statistics counter slots
	localparam int CTR_REPORTS    = 0;
	localparam int CTR_TIMEOUTS   = 1;
	localparam int CTR_NAKS       = 2;
	localparam int CTR_DMA        = 3;
	localparam int CTR_ARB_LOST   = 4;
	localparam int CTR_FALLBACKS  = 5;
	localparam int CTR_RESETS     = 6;
	localparam int CTR_RESETS_REC = 7;

	localparam logic [CE_W-1:0]   CE_MAX        = 8'hFF;
	localparam logic [CE_W-1:0]   CE_RESET_MIN  = 8'd10;
	localparam logic [CE_W-1:0]   CE_DMA_RESET  = 8'd5;
	localparam logic [SRUN_W-1:0] SRUN_EXIT     = 4'd10;

	localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 8'd3;
	localparam logic [DELAY_W-1:0] DELAY_BASE_RST  = 16'd10;
	localparam logic [DELAY_W-1:0] DELAY_CAP_RST   = 16'd1000;

	typedef struct packed {
		logic                clear;
		logic [NUM_CTRS-1:0] bump;
	} ctr_ctl_t;

	function automatic logic [SEV_W-1:0] grade_f(
		input logic [CODE_W-1:0]  code,
		input logic [RETRY_W-1:0] retry
	);
		logic [SEV_W-1:0] sev;
		case (code)
			ERR_OK:        sev = SEV_INFO;
			ERR_BUSY:      sev = (retry > 8'd2) ? SEV_WARNING : SEV_INFO;
			ERR_TIMEOUT:   sev = (retry > 8'd3) ? SEV_ERROR : SEV_WARNING;
			ERR_NAK:       sev = (retry > 8'd2) ? SEV_ERROR : SEV_WARNING;
			ERR_ARB_LOST:  sev = SEV_WARNING;
			ERR_DMA:       sev = (retry > 8'd1) ? SEV_CRITICAL : SEV_ERROR;
			ERR_BAD_PARAM: sev = SEV_CRITICAL;
			ERR_NOT_INIT:  sev = SEV_FATAL;
			default:       sev = SEV_ERROR;
		endcase
		return sev;
	endfunction

	function automatic logic [ACT_W-1:0] choose_f(
		input logic [CODE_W-1:0]  code,
		input logic [RETRY_W-1:0] retry,
		input logic [RETRY_W-1:0] limit,
		input logic [CE_W-1:0]    run
	);
		logic [ACT_W-1:0] act;
		case (code)
			ERR_BUSY:      act = (retry < 8'd2) ? ACT_RETRY_DELAYED : ACT_FALLBACK;
			ERR_TIMEOUT:   act = (retry < limit) ? ACT_RETRY_DELAYED : ACT_FALLBACK;
			ERR_NAK:       act = (retry < 8'd3) ? ACT_RETRY_NOW : ACT_FALLBACK;
			ERR_ARB_LOST:  act = ACT_RETRY_DELAYED;
			ERR_DMA: begin
				if (retry == '0)
					act = ACT_RETRY_NOW;
				else
					act = (run > CE_DMA_RESET) ? ACT_RESET_PERIPH : ACT_FALLBACK;
			end
			ERR_BAD_PARAM: act = ACT_RESTART;
			ERR_NOT_INIT:  act = ACT_RESTART;
			default:       act = ACT_FALLBACK;
		endcase
		return act;
	endfunction

endpackage

// File: src/lerp_req_if.sv
// request channel: valid/ready handshake with the command item fields
// depends on lerp_pkg for field widths
interface lerp_req_if;
	logic                           valid;
	logic                           ready;
	logic [lerp_pkg::CMD_W-1:0]     command;
	logic [lerp_pkg::CHAN_W-1:0]    channel;
	logic [lerp_pkg::CODE_W-1:0]    fault_code;
	logic [lerp_pkg::RETRY_W-1:0]   retries_made;
	logic [lerp_pkg::ACT_W-1:0]     action_in;
	logic [lerp_pkg::SEL_W-1:0]     counter_select;

	modport source (output valid, command, channel, fault_code, retries_made, action_in,
		counter_select, input ready);
	modport sink (input valid, command, channel, fault_code, retries_made, action_in,
		counter_select, output ready);
endinterface

// File: src/lerp_rsp_if.sv
// response channel: valid/ready handshake with the result item fields
// depends on lerp_pkg for field widths
interface lerp_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [lerp_pkg::SEV_W-1:0]     severity;
	logic [lerp_pkg::ACT_W-1:0]     recovery_action;
	logic [lerp_pkg::DELAY_W-1:0]   retry_delay_ms;
	logic                           recovery_ok;
	logic                           peripheral_reset_pulse;
	logic                           restart_request;
	logic [lerp_pkg::MASK_W-1:0]    fallback_mask;
	logic [lerp_pkg::CTR_W-1:0]     counter_value;

	modport source (output valid, severity, recovery_action, retry_delay_ms, recovery_ok,
		peripheral_reset_pulse, restart_request, fallback_mask, counter_value, input ready);
	modport sink (input valid, severity, recovery_action, retry_delay_ms, recovery_ok,
		peripheral_reset_pulse, restart_request, fallback_mask, counter_value, output ready);
endinterface

// File: src/lerp_cfg_if.sv
// configuration write channel: valid/ready with register index and write data
// depends on lerp_pkg for widths
interface lerp_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [lerp_pkg::REG_IDX_W-1:0]   idx;
	logic [lerp_pkg::REG_DATA_W-1:0]  wdata;

	modport source (output valid, idx, wdata, input ready);
	modport sink (input valid, idx, wdata, output ready);
endinterface

// File: src/lerp_ctrs.sv
// bank of eight saturating statistics counters with clear and one read port
// depends on lerp_pkg for widths and the control struct
module lerp_ctrs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lerp_pkg::ctr_ctl_t             ctl,
	input  logic [lerp_pkg::SEL_W-1:0]     sel,
	output logic [lerp_pkg::CTR_W-1:0]     rd_data
);
	import lerp_pkg::*;

	logic [CTR_W-1:0] ctr_q [NUM_CTRS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CTRS; i++)
				ctr_q[i] <= '0;
		end else if (ctl.clear) begin
			for (int i = 0; i < NUM_CTRS; i++)
				ctr_q[i] <= '0;
		end else begin
			for (int i = 0; i < NUM_CTRS; i++)
				if (ctl.bump[i] && (ctr_q[i] != '1))
					ctr_q[i] <= ctr_q[i] + 1'b1;
		end
	end

	assign rd_data = ctr_q[sel];

endmodule

// File: src/link_error_recovery_policy_unit.sv
// an accepted item is loaded into the input register, then into the result register once
// that is empty or being taken; channel state is read and written back as the item moves
// throughput: one item per cycle unless the receiver stalls the result channel
// reset: all channel state and counters cleared, registers to defaults
// depends on lerp_pkg, lerp_req_if, lerp_rsp_if, lerp_cfg_if and lerp_ctrs
module link_error_recovery_policy_unit #(
	parameter int CHANNELS = lerp_pkg::CHANNELS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lerp_req_if.sink   req_ch,
	lerp_rsp_if.source rsp_ch,
	lerp_cfg_if.sink   cfg_ch
);
	import lerp_pkg::*;

	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int MASK_N = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;
	localparam logic [CHAN_W:0] CH_CNT = (CHAN_W+1)'(CHANNELS);

	// configuration
	logic [RETRY_W-1:0] retry_limit_q;
	logic [DELAY_W-1:0] delay_base_q;
	logic [DELAY_W-1:0] delay_cap_q;
	logic               allow_fb_q;
	logic               allow_preset_q;

	// input register
	logic               vld_s1;
	logic [CMD_W-1:0]   cmd_s1;
	logic [CHAN_W-1:0]  chan_s1;
	logic [CODE_W-1:0]  code_s1;
	logic [RETRY_W-1:0] retry_s1;
	logic [ACT_W-1:0]   act_s1;
	logic [SEL_W-1:0]   sel_s1;

	// channel state
	logic [CE_W-1:0]     ce_q [CHANNELS];
	logic [SRUN_W-1:0]   srun_q [CHANNELS];
	logic [CHANNELS-1:0] fb_q;

	// result register
	logic               out_vld_q;
	logic [SEV_W-1:0]   sev_q;
	logic [ACT_W-1:0]   action_q;
	logic [DELAY_W-1:0] delay_q;
	logic               ok_q;
	logic               pulse_q;
	logic               restart_q;
	logic [MASK_W-1:0]  mask_q;
	logic [CTR_W-1:0]   value_q;

	logic                adv;
	logic                chan_ok;
	logic [CH_W-1:0]     ch_idx;
	logic [CE_W-1:0]     cur_ce;
	logic [SRUN_W-1:0]   cur_srun;
	logic                cur_fb;
	logic                ce_we;
	logic [CE_W-1:0]     ce_nxt;
	logic                srun_we;
	logic [SRUN_W-1:0]   srun_nxt;
	logic                fb_we;
	logic                fb_nxt;
	logic                clr;
	logic [CHANNELS-1:0] fb_d;
	logic [SEV_W-1:0]    sev_d;
	logic [ACT_W-1:0]    action_d;
	logic [DELAY_W-1:0]  delay_d;
	logic                ok_d;
	logic                pulse_d;
	logic                restart_d;
	logic [MASK_W-1:0]   mask_d;
	logic [CTR_W-1:0]    value_d;
	logic [CTR_W-1:0]    ctr_rd;
	logic [CTR_W-1:0]    shifted;
	logic                retry_pass;
	logic [SRUN_W-1:0]   srun_inc;
	logic [NUM_CTRS-1:0] bump;
	ctr_ctl_t            ctr_ctl;

	assign adv          = vld_s1 && (!out_vld_q || rsp_ch.ready);
	assign req_ch.ready = !vld_s1 || adv;
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q  <= RETRY_LIMIT_RST;
			delay_base_q   <= DELAY_BASE_RST;
			delay_cap_q    <= DELAY_CAP_RST;
			allow_fb_q     <= 1'b1;
			allow_preset_q <= 1'b1;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.idx)
				REG_RETRY_LIMIT:  retry_limit_q  <= cfg_ch.wdata[RETRY_W-1:0];
				REG_DELAY_BASE:   delay_base_q   <= cfg_ch.wdata;
				REG_DELAY_CAP:    delay_cap_q    <= cfg_ch.wdata;
				REG_ALLOW_FB:     allow_fb_q     <= cfg_ch.wdata[0];
				REG_ALLOW_PRESET: allow_preset_q <= cfg_ch.wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (req_ch.valid && req_ch.ready)
			vld_s1 <= 1'b1;
		else if (adv)
			vld_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (req_ch.valid && req_ch.ready) begin
			cmd_s1   <= req_ch.command;
			chan_s1  <= req_ch.channel;
			code_s1  <= req_ch.fault_code;
			retry_s1 <= req_ch.retries_made;
			act_s1   <= req_ch.action_in;
			sel_s1   <= req_ch.counter_select;
		end
	end

	// out-of-range report channels fold onto channel 0
	assign chan_ok  = {1'b0, chan_s1} < CH_CNT;
	assign ch_idx   = chan_ok ? chan_s1[CH_W-1:0] : '0;
	assign cur_ce   = ce_q[ch_idx];
	assign cur_srun = srun_q[ch_idx];
	assign cur_fb   = fb_q[ch_idx];
	assign srun_inc = cur_srun + 1'b1;
	assign shifted  = {{(CTR_W-DELAY_W){1'b0}}, delay_base_q} << retry_s1[3:0];
	assign retry_pass = ({1'b0, retry_s1} + 9'd1) < {1'b0, retry_limit_q};

	always_comb begin
		sev_d     = SEV_INFO;
		action_d  = ACT_NONE;
		delay_d   = '0;
		ok_d      = 1'b0;
		pulse_d   = 1'b0;
		restart_d = 1'b0;
		value_d   = '0;
		ce_we     = 1'b0;
		ce_nxt    = '0;
		srun_we   = 1'b0;
		srun_nxt  = cur_srun;
		fb_we     = 1'b0;
		fb_nxt    = cur_fb;
		clr       = 1'b0;
		bump      = '0;
		case (cmd_s1)
			CMD_REPORT: begin
				sev_d    = grade_f(code_s1, retry_s1);
				action_d = choose_f(code_s1, retry_s1, retry_limit_q, cur_ce);
				bump[CTR_REPORTS]  = 1'b1;
				bump[CTR_TIMEOUTS] = (code_s1 == ERR_TIMEOUT);
				bump[CTR_NAKS]     = (code_s1 == ERR_NAK);
				bump[CTR_DMA]      = (code_s1 == ERR_DMA);
				bump[CTR_ARB_LOST] = (code_s1 == ERR_ARB_LOST);
				ce_we  = 1'b1;
				ce_nxt = (cur_ce == CE_MAX) ? cur_ce : cur_ce + 1'b1;
			end
			CMD_SUCCESS: begin
				if (chan_ok) begin
					ce_we = 1'b1;
					if (cur_fb) begin
						srun_we = 1'b1;
						if (srun_inc > SRUN_EXIT) begin
							srun_nxt = '0;
							fb_we    = 1'b1;
							fb_nxt   = 1'b0;
						end else begin
							srun_nxt = srun_inc;
						end
					end
				end
			end
			CMD_EXECUTE: begin
				if (chan_ok) begin
					case (act_s1)
						ACT_RETRY_NOW, ACT_RETRY_DELAYED: begin
							if (act_s1 == ACT_RETRY_DELAYED) begin
								if (retry_s1 >= 8'd16)
									delay_d = delay_cap_q;
								else if (shifted < {{(CTR_W-DELAY_W){1'b0}}, delay_cap_q})
									delay_d = shifted[DELAY_W-1:0];
								else
									delay_d = delay_cap_q;
							end
							if (retry_pass) begin
								ce_we = 1'b1;
								ok_d  = 1'b1;
							end
						end
						ACT_FALLBACK: begin
							if (allow_fb_q) begin
								fb_we  = 1'b1;
								fb_nxt = 1'b1;
								bump[CTR_FALLBACKS] = 1'b1;
								ok_d   = 1'b1;
							end
						end
						ACT_RESET_PERIPH: begin
							if (allow_preset_q && (cur_ce > CE_RESET_MIN)) begin
								ce_we   = 1'b1;
								bump[CTR_RESETS]     = 1'b1;
								bump[CTR_RESETS_REC] = 1'b1;
								pulse_d = 1'b1;
								ok_d    = 1'b1;
							end
						end
						ACT_RESTART: restart_d = 1'b1;
						default: ;
					endcase
				end
			end
			CMD_CLEAR: clr = 1'b1;
			CMD_READ: value_d = ctr_rd;
			CMD_LEAVE_FB: begin
				if (chan_ok) begin
					fb_we  = 1'b1;
					fb_nxt = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		fb_d = fb_q;
		if (clr)
			fb_d = '0;
		else if (fb_we)
			fb_d[ch_idx] = fb_nxt;
		mask_d = '0;
		for (int c = 0; c < MASK_N; c++)
			mask_d[c] = fb_d[c];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_q <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				ce_q[c]   <= '0;
				srun_q[c] <= '0;
			end
		end else if (adv) begin
			fb_q <= fb_d;
			if (clr) begin
				for (int c = 0; c < CHANNELS; c++)
					ce_q[c] <= '0;
			end else if (ce_we) begin
				ce_q[ch_idx] <= ce_nxt;
			end
			if (srun_we)
				srun_q[ch_idx] <= srun_nxt;
		end
	end

	assign ctr_ctl.clear = adv && clr;
	assign ctr_ctl.bump  = adv ? bump : '0;

	lerp_ctrs u_ctrs (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctr_ctl),
		.sel     (sel_s1),
		.rd_data (ctr_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (adv)
			out_vld_q <= 1'b1;
		else if (rsp_ch.ready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sev_q     <= sev_d;
			action_q  <= action_d;
			delay_q   <= delay_d;
			ok_q      <= ok_d;
			pulse_q   <= pulse_d;
			restart_q <= restart_d;
			mask_q    <= mask_d;
			value_q   <= value_d;
		end
	end

	assign rsp_ch.valid                  = out_vld_q;
	assign rsp_ch.severity               = sev_q;
	assign rsp_ch.recovery_action        = action_q;
	assign rsp_ch.retry_delay_ms         = delay_q;
	assign rsp_ch.recovery_ok            = ok_q;
	assign rsp_ch.peripheral_reset_pulse = pulse_q;
	assign rsp_ch.restart_request        = restart_q;
	assign rsp_ch.fallback_mask          = mask_q;
	assign rsp_ch.counter_value          = value_q;

endmodule

// File: src/lerp_checker.sv
// port-level checks on the result channel of the recovery policy unit
// depends on lerp_pkg and link_error_recovery_policy_unit_defines.svh; bound to the top level
`include "link_error_recovery_policy_unit_defines.svh"

module lerp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [2:0]  severity,
	input logic [2:0]  recovery_action,
	input logic [15:0] retry_delay_ms,
	input logic        recovery_ok,
	input logic        peripheral_reset_pulse,
	input logic        restart_request
);
	import lerp_pkg::*;

	`LERP_ASSERT_NEXT(a_hold_stall, clk, arst_n, valid && !ready, valid && $stable(recovery_ok) && $stable(retry_delay_ms))
	`LERP_ASSERT_NOW(a_restart_not_ok, clk, arst_n, valid && restart_request, !recovery_ok && !peripheral_reset_pulse)
	`LERP_ASSERT_NOW(a_pulse_ok, clk, arst_n, valid && peripheral_reset_pulse, recovery_ok && retry_delay_ms == 16'd0)
	`LERP_ASSERT_NOW(a_delay_exec_only, clk, arst_n, valid && retry_delay_ms != 16'd0, severity == SEV_INFO && recovery_action == ACT_NONE)

endmodule

bind link_error_recovery_policy_unit lerp_checker u_lerp_checker (
	.clk                    (clk),
	.arst_n                 (arst_n),
	.valid                  (rsp_ch.valid),
	.ready                  (rsp_ch.ready),
	.severity               (rsp_ch.severity),
	.recovery_action        (rsp_ch.recovery_action),
	.retry_delay_ms         (rsp_ch.retry_delay_ms),
	.recovery_ok            (rsp_ch.recovery_ok),
	.peripheral_reset_pulse (rsp_ch.peripheral_reset_pulse),
	.restart_request        (rsp_ch.restart_request)
);

// File: tb/sv/lerp_policy_tracker_pkg.sv
// scoreboard for the link error recovery policy unit: keeps its own copy of the
// channel state, counters and registers, predicts every result item and checks it
// depends on lerp_pkg for widths, codes, register indexes and counter slots
package lerp_policy_tracker_pkg;
	import lerp_pkg::*;

	localparam int TRACKED_CHANNELS = CHANNELS_DEF;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [CHAN_W-1:0]  channel;
		logic [CODE_W-1:0]  fault_code;
		logic [RETRY_W-1:0] retries_made;
		logic [ACT_W-1:0]   action_in;
		logic [SEL_W-1:0]   counter_select;
	} policy_request_t;

	typedef struct packed {
		logic [SEV_W-1:0]   severity;
		logic [ACT_W-1:0]   recovery_action;
		logic [DELAY_W-1:0] retry_delay_ms;
		logic               recovery_ok;
		logic               peripheral_reset_pulse;
		logic               restart_request;
		logic [MASK_W-1:0]  fallback_mask;
		logic [CTR_W-1:0]   counter_value;
	} policy_outcome_t;

	class recovery_policy_tracker;
		logic [RETRY_W-1:0] retry_limit;
		logic [DELAY_W-1:0] delay_base;
		logic [DELAY_W-1:0] delay_cap;
		logic               fallback_allowed;
		logic               reset_allowed;
		logic [CE_W-1:0]    error_run[TRACKED_CHANNELS];
		logic               in_fallback[TRACKED_CHANNELS];
		logic [SRUN_W-1:0]  clean_run[TRACKED_CHANNELS];
		logic [CTR_W-1:0]   tally[NUM_CTRS];
		policy_outcome_t    awaited[$];
		int                 mismatches;

		function new();
			retry_limit = RETRY_LIMIT_RST;
			delay_base = DELAY_BASE_RST;
			delay_cap = DELAY_CAP_RST;
			fallback_allowed = 1'b1;
			reset_allowed = 1'b1;
			foreach (error_run[c]) begin
				error_run[c] = '0;
				in_fallback[c] = 1'b0;
				clean_run[c] = '0;
			end
			foreach (tally[s]) tally[s] = '0;
			mismatches = 0;
		endfunction

		function void write_register(logic [REG_IDX_W-1:0] idx, logic [REG_DATA_W-1:0] data);
			case (idx)
				REG_RETRY_LIMIT:  retry_limit = data[RETRY_W-1:0];
				REG_DELAY_BASE:   delay_base = data[DELAY_W-1:0];
				REG_DELAY_CAP:    delay_cap = data[DELAY_W-1:0];
				REG_ALLOW_FB:     fallback_allowed = data[0];
				REG_ALLOW_PRESET: reset_allowed = data[0];
				default: ;
			endcase
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction

		function void bump(int slot);
			if (tally[slot] != '1)
				tally[slot] = tally[slot] + 1'b1;
		endfunction

		function logic [SEV_W-1:0] grade(logic [CODE_W-1:0] code, logic [RETRY_W-1:0] retry);
			case (code)
				ERR_OK:        return SEV_INFO;
				ERR_BUSY:      return (retry >= 3) ? SEV_WARNING : SEV_INFO;
				ERR_TIMEOUT:   return (retry >= 4) ? SEV_ERROR : SEV_WARNING;
				ERR_NAK:       return (retry >= 3) ? SEV_ERROR : SEV_WARNING;
				ERR_ARB_LOST:  return SEV_WARNING;
				ERR_DMA:       return (retry >= 2) ? SEV_CRITICAL : SEV_ERROR;
				ERR_BAD_PARAM: return SEV_CRITICAL;
				ERR_NOT_INIT:  return SEV_FATAL;
				default:       return SEV_ERROR;
			endcase
		endfunction

		// advice uses the error run as it stood before this report
		function logic [ACT_W-1:0] advise(logic [CODE_W-1:0] code, logic [RETRY_W-1:0] retry,
			logic [CE_W-1:0] run);
			case (code)
				ERR_BUSY:      return (retry <= 1) ? ACT_RETRY_DELAYED : ACT_FALLBACK;
				ERR_TIMEOUT:   return (retry < retry_limit) ? ACT_RETRY_DELAYED : ACT_FALLBACK;
				ERR_NAK:       return (retry <= 2) ? ACT_RETRY_NOW : ACT_FALLBACK;
				ERR_ARB_LOST:  return ACT_RETRY_DELAYED;
				ERR_DMA: begin
					if (retry == 0)
						return ACT_RETRY_NOW;
					return (run >= 6) ? ACT_RESET_PERIPH : ACT_FALLBACK;
				end
				ERR_BAD_PARAM, ERR_NOT_INIT: return ACT_RESTART;
				default:       return ACT_FALLBACK;
			endcase
		endfunction

		function logic [DELAY_W-1:0] backoff(logic [RETRY_W-1:0] retry);
			logic [31:0] scaled;
			if (retry >= 16)
				return delay_cap;
			scaled = {16'd0, delay_base} << retry;
			return (scaled < {16'd0, delay_cap}) ? scaled[DELAY_W-1:0] : delay_cap;
		endfunction

		function void execute(policy_request_t r, int unsigned c, inout policy_outcome_t o);
			case (r.action_in)
				ACT_RETRY_NOW, ACT_RETRY_DELAYED: begin
					if (r.action_in == ACT_RETRY_DELAYED)
						o.retry_delay_ms = backoff(r.retries_made);
					if (int'(r.retries_made) + 1 < int'(retry_limit)) begin
						error_run[c] = '0;
						o.recovery_ok = 1'b1;
					end
				end
				ACT_FALLBACK: begin
					if (fallback_allowed) begin
						in_fallback[c] = 1'b1;
						bump(CTR_FALLBACKS);
						o.recovery_ok = 1'b1;
					end
				end
				ACT_RESET_PERIPH: begin
					if (reset_allowed && error_run[c] > CE_RESET_MIN) begin
						error_run[c] = '0;
						bump(CTR_RESETS);
						bump(CTR_RESETS_REC);
						o.peripheral_reset_pulse = 1'b1;
						o.recovery_ok = 1'b1;
					end
				end
				ACT_RESTART: o.restart_request = 1'b1;
				default: ;
			endcase
		endfunction

		function void note_request(policy_request_t r);
			policy_outcome_t o;
			int unsigned c;
			bit in_range;
			o = '0;
			c = r.channel;
			in_range = (r.channel < TRACKED_CHANNELS);
			case (r.command)
				CMD_REPORT: begin
					if (!in_range)
						c = 0;
					o.severity = grade(r.fault_code, r.retries_made);
					o.recovery_action = advise(r.fault_code, r.retries_made, error_run[c]);
					bump(CTR_REPORTS);
					case (r.fault_code)
						ERR_TIMEOUT:  bump(CTR_TIMEOUTS);
						ERR_NAK:      bump(CTR_NAKS);
						ERR_DMA:      bump(CTR_DMA);
						ERR_ARB_LOST: bump(CTR_ARB_LOST);
						default: ;
					endcase
					if (error_run[c] != CE_MAX)
						error_run[c] = error_run[c] + 1'b1;
				end
				CMD_SUCCESS: begin
					if (in_range) begin
						error_run[c] = '0;
						if (in_fallback[c]) begin
							clean_run[c] = clean_run[c] + 1'b1;
							if (clean_run[c] > SRUN_EXIT) begin
								in_fallback[c] = 1'b0;
								clean_run[c] = '0;
							end
						end
					end
				end
				CMD_EXECUTE: begin
					if (in_range)
						execute(r, c, o);
				end
				CMD_CLEAR: begin
					foreach (error_run[k]) begin
						error_run[k] = '0;
						in_fallback[k] = 1'b0;
					end
					foreach (tally[s]) tally[s] = '0;
				end
				CMD_READ:     o.counter_value = tally[r.counter_select];
				CMD_LEAVE_FB: begin
					if (in_range)
						in_fallback[c] = 1'b0;
				end
				default: ;
			endcase
			for (int k = 0; k < TRACKED_CHANNELS && k < MASK_W; k++)
				o.fallback_mask[k] = in_fallback[k];
			awaited.push_back(o);
		endfunction

		function void check_field(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_response(policy_outcome_t got);
			policy_outcome_t want;
			if (awaited.size() == 0) begin
				$error("result item with no expectation waiting");
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			check_field("severity", want.severity, got.severity);
			check_field("recovery_action", want.recovery_action, got.recovery_action);
			check_field("retry_delay_ms", want.retry_delay_ms, got.retry_delay_ms);
			check_field("recovery_ok", want.recovery_ok, got.recovery_ok);
			check_field("peripheral_reset_pulse", want.peripheral_reset_pulse,
				got.peripheral_reset_pulse);
			check_field("restart_request", want.restart_request, got.restart_request);
			check_field("fallback_mask", want.fallback_mask, got.fallback_mask);
			check_field("counter_value", want.counter_value, got.counter_value);
		endfunction
	endclass

endpackage

// File: tb/sv/tb_link_error_recovery_policy_unit.sv
// top-level testbench for link_error_recovery_policy_unit: directed and random
// request items over several register settings, random idling on both channels
// depends on lerp_pkg, the lerp channel interfaces and lerp_policy_tracker_pkg
module tb_link_error_recovery_policy_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import lerp_pkg::*;
	import lerp_policy_tracker_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 120;
	localparam int DRAIN_CYCLES = 6;

	localparam logic [CMD_W-1:0]  CMD_UNUSED    = '1;
	localparam logic [ACT_W-1:0]  ACT_UNUSED    = '1;
	localparam logic [CODE_W-1:0] ERR_OTHER_MAX = '1;

	logic clk = 1'b0;
	logic arst_n;

	lerp_req_if req_bus();
	lerp_rsp_if rsp_bus();
	lerp_cfg_if cfg_bus();

	link_error_recovery_policy_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req_ch (req_bus),
		.rsp_ch (rsp_bus),
		.cfg_ch (cfg_bus)
	);

	recovery_policy_tracker tracker;
	int idle_cycles = 0;
	int sender_steady = 0;
	int receiver_steady = 0;
	int items_sent = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (cfg_bus.valid && cfg_bus.ready)
				tracker.write_register(cfg_bus.idx, cfg_bus.wdata);
			if (req_bus.valid && req_bus.ready)
				tracker.note_request(policy_request_t'{req_bus.command, req_bus.channel,
					req_bus.fault_code, req_bus.retries_made, req_bus.action_in,
					req_bus.counter_select});
			if (rsp_bus.valid && rsp_bus.ready)
				tracker.check_response(policy_outcome_t'{rsp_bus.severity,
					rsp_bus.recovery_action, rsp_bus.retry_delay_ms, rsp_bus.recovery_ok,
					rsp_bus.peripheral_reset_pulse, rsp_bus.restart_request,
					rsp_bus.fallback_mask, rsp_bus.counter_value});
			if ((cfg_bus.valid && cfg_bus.ready) || (req_bus.valid && req_bus.ready) ||
				(rsp_bus.valid && rsp_bus.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("link_error_recovery_policy_unit test failed");
				$finish;
			end
		end
	end

	function automatic int draw_gap(inout int steady_left);
		if (steady_left > 0) begin
			steady_left--;
			return 0;
		end
		if ($urandom_range(0, 31) == 0)
			steady_left = $urandom_range(10, 40);
		return $urandom_range(0, 7);
	endfunction

	function automatic logic [RETRY_W-1:0] pick_retry();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return RETRY_W'($urandom_range(0, 5));
		if (roll < 85)
			return RETRY_W'($urandom_range(6, 20));
		return RETRY_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [CODE_W-1:0] pick_code();
		if ($urandom_range(0, 9) < 8)
			return CODE_W'($urandom_range(0, 7));
		return CODE_W'($urandom_range(0, 15));
	endfunction

	function automatic logic [CHAN_W-1:0] pick_channel();
		if ($urandom_range(0, 9) < 9)
			return CHAN_W'($urandom_range(0, TRACKED_CHANNELS - 1));
		return CHAN_W'($urandom_range(0, 7));
	endfunction

	task automatic issue(input logic [CMD_W-1:0] command, input logic [CHAN_W-1:0] channel,
		input logic [CODE_W-1:0] code, input logic [RETRY_W-1:0] retry,
		input logic [ACT_W-1:0] action, input logic [SEL_W-1:0] sel);
		int gap;
		gap = draw_gap(sender_steady);
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.command <= command;
		req_bus.channel <= channel;
		req_bus.fault_code <= code;
		req_bus.retries_made <= retry;
		req_bus.action_in <= action;
		req_bus.counter_select <= sel;
		do @(posedge clk); while (!req_bus.ready);
		items_sent++;
	endtask

	task automatic settle();
		req_bus.valid <= 1'b0;
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_config(input logic [RETRY_W-1:0] limit, input logic [DELAY_W-1:0] base,
		input logic [DELAY_W-1:0] cap, input logic fb_ok, input logic reset_ok);
		logic [REG_IDX_W-1:0]  which[5];
		logic [REG_DATA_W-1:0] value[5];
		which = '{REG_RETRY_LIMIT, REG_DELAY_BASE, REG_DELAY_CAP, REG_ALLOW_FB,
			REG_ALLOW_PRESET};
		value = '{REG_DATA_W'(limit), base, cap, REG_DATA_W'(fb_ok), REG_DATA_W'(reset_ok)};
		foreach (which[i]) begin
			cfg_bus.valid <= 1'b1;
			cfg_bus.idx <= which[i];
			cfg_bus.wdata <= value[i];
			do @(posedge clk); while (!cfg_bus.ready);
		end
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic run_random(input int count);
		int goal;
		int roll;
		int n;
		logic [CHAN_W-1:0] ch;
		goal = items_sent + count;
		while (items_sent < goal) begin
			roll = $urandom_range(0, 99);
			ch = pick_channel();
			if (roll < 35) begin
				// error burst on one channel, then usually an attempt to recover
				n = $urandom_range(1, 14);
				repeat (n)
					issue(CMD_REPORT, ch, pick_code(), pick_retry(), ACT_W'($urandom),
						SEL_W'($urandom));
				if ($urandom_range(0, 9) < 7)
					issue(CMD_EXECUTE, ch, CODE_W'($urandom), pick_retry(),
						ACT_W'($urandom_range(ACT_RETRY_NOW, ACT_RESTART)), SEL_W'($urandom));
				if ($urandom_range(0, 9) < 3)
					issue(CMD_SUCCESS, ch, CODE_W'($urandom), RETRY_W'($urandom),
						ACT_W'($urandom), SEL_W'($urandom));
			end else if (roll < 50) begin
				// fallback followed by a run of successes
				issue(CMD_EXECUTE, ch, CODE_W'($urandom), RETRY_W'($urandom), ACT_FALLBACK,
					SEL_W'($urandom));
				n = $urandom_range(8, 13);
				repeat (n) begin
					if ($urandom_range(0, 4) == 0)
						issue(CMD_REPORT, pick_channel(), pick_code(), pick_retry(),
							ACT_W'($urandom), SEL_W'($urandom));
					issue(CMD_SUCCESS, ch, CODE_W'($urandom), RETRY_W'($urandom),
						ACT_W'($urandom), SEL_W'($urandom));
				end
			end else if (roll < 65) begin
				issue(CMD_EXECUTE, ch, CODE_W'($urandom), pick_retry(),
					($urandom_range(0, 1) == 0) ? ACT_RETRY_NOW : ACT_RETRY_DELAYED,
					SEL_W'($urandom));
			end else if (roll < 75) begin
				issue(CMD_READ, CHAN_W'($urandom), CODE_W'($urandom), RETRY_W'($urandom),
					ACT_W'($urandom), SEL_W'($urandom));
			end else if (roll < 80) begin
				issue(($urandom_range(0, 1) == 0) ? CMD_CLEAR : CMD_LEAVE_FB, ch,
					CODE_W'($urandom), RETRY_W'($urandom), ACT_W'($urandom), SEL_W'($urandom));
			end else begin
				issue(CMD_W'($urandom), CHAN_W'($urandom), CODE_W'($urandom), RETRY_W'($urandom),
					ACT_W'($urandom), SEL_W'($urandom));
			end
		end
	endtask

	initial begin
		int gap;
		int taken;
		taken = 0;
		rsp_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = draw_gap(receiver_steady);
			if (gap > 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_bus.ready <= 1'b1;
			do @(posedge clk); while (!rsp_bus.valid);
			taken++;
			// long hold-off so the block backs up and stalls its input
			if (taken % 400 == 150) begin
				rsp_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
		end
	end

	initial begin
		tracker = new();
		arst_n <= 1'b0;
		req_bus.valid <= 1'b0;
		req_bus.command <= CMD_REPORT;
		req_bus.channel <= '0;
		req_bus.fault_code <= ERR_OK;
		req_bus.retries_made <= '0;
		req_bus.action_in <= ACT_NONE;
		req_bus.counter_select <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.idx <= REG_RETRY_LIMIT;
		cfg_bus.wdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// grading and advice for every code on one channel
		issue(CMD_REPORT, 3'd1, ERR_OK, 8'd0, ACT_NONE, '0);
		issue(CMD_REPORT, 3'd1, ERR_DMA, 8'd2, ACT_NONE, '0);
		issue(CMD_REPORT, 3'd1, ERR_BUSY, 8'd3, ACT_NONE, '0);
		issue(CMD_REPORT, 3'd1, ERR_TIMEOUT, 8'd4, ACT_NONE, '0);
		issue(CMD_REPORT, 3'd1, ERR_NAK, 8'd2, ACT_NONE, '0);
		issue(CMD_REPORT, 3'd1, ERR_ARB_LOST, 8'd0, ACT_NONE, '0);
		issue(CMD_REPORT, 3'd1, ERR_DMA, 8'd0, ACT_NONE, '0);
		issue(CMD_REPORT, 3'd1, ERR_DMA, 8'd1, ACT_NONE, '0);
		issue(CMD_REPORT, 3'd1, ERR_BAD_PARAM, 8'd0, ACT_NONE, '0);
		issue(CMD_REPORT, 3'd1, ERR_NOT_INIT, 8'd0, ACT_NONE, '0);
		// peripheral reset refused at a run of ten, fired at eleven
		issue(CMD_EXECUTE, 3'd1, ERR_OK, 8'd0, ACT_RESET_PERIPH, '0);
		issue(CMD_REPORT, 3'd1, ERR_OTHER_MAX, 8'hFF, ACT_UNUSED, '1);
		issue(CMD_EXECUTE, 3'd1, ERR_OK, 8'd0, ACT_RESET_PERIPH, '0);
		issue(CMD_REPORT, 3'd7, ERR_ARB_LOST, 8'd0, ACT_NONE, '0);
		// retries: accepted, large shift, refused
		issue(CMD_EXECUTE, 3'd2, ERR_OK, 8'd1, ACT_RETRY_DELAYED, '0);
		issue(CMD_EXECUTE, 3'd2, ERR_OK, 8'd20, ACT_RETRY_DELAYED, '0);
		issue(CMD_EXECUTE, 3'd2, ERR_OK, 8'd2, ACT_RETRY_NOW, '0);
		issue(CMD_EXECUTE, 3'd3, ERR_OK, 8'd0, ACT_FALLBACK, '0);
		issue(CMD_EXECUTE, 3'd3, ERR_OK, 8'd0, ACT_RESTART, '0);
		issue(CMD_EXECUTE, 3'd0, ERR_OK, 8'd0, ACT_UNUSED, '0);
		issue(CMD_EXECUTE, 3'd5, ERR_OK, 8'd0, ACT_FALLBACK, '0);
		issue(CMD_SUCCESS, 3'd3, ERR_OK, 8'd0, ACT_NONE, '0);
		issue(CMD_SUCCESS, 3'd6, ERR_OK, 8'd0, ACT_NONE, '0);
		issue(CMD_READ, 3'd0, ERR_OK, 8'd0, ACT_NONE, SEL_W'(CTR_RESETS_REC));
		issue(CMD_LEAVE_FB, 3'd3, ERR_OK, 8'd0, ACT_NONE, '0);
		issue(CMD_UNUSED, 3'd0, ERR_OK, 8'd0, ACT_NONE, '0);
		issue(CMD_CLEAR, 3'd0, ERR_OK, 8'd0, ACT_NONE, '0);
		issue(CMD_READ, 3'd0, ERR_OK, 8'd0, ACT_NONE, SEL_W'(CTR_REPORTS));
		run_random(300);

		settle();
		write_config(8'd0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
		// drive one error run into saturation
		repeat (260)
			issue(CMD_REPORT, 3'd2, pick_code(), pick_retry(), ACT_W'($urandom), SEL_W'($urandom));
		issue(CMD_EXECUTE, 3'd2, ERR_OK, 8'd0, ACT_RESET_PERIPH, '0);
		issue(CMD_EXECUTE, 3'd2, ERR_OK, 8'd0, ACT_FALLBACK, '0);
		run_random(150);

		settle();
		write_config(8'd255, 16'd1, 16'd0, 1'b1, 1'b1);
		run_random(200);

		repeat (2) begin
			settle();
			write_config(RETRY_W'($urandom_range(1, 8)), DELAY_W'($urandom_range(0, 400)),
				DELAY_W'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			run_random(110);
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.outstanding() == 0)
			$display("link_error_recovery_policy_unit test passed");
		else
			$display("link_error_recovery_policy_unit test failed");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+src
src/lerp_pkg.sv
src/lerp_req_if.sv
src/lerp_rsp_if.sv
src/lerp_cfg_if.sv
src/lerp_ctrs.sv
src/link_error_recovery_policy_unit.sv
src/lerp_checker.sv
tb/sv/lerp_policy_tracker_pkg.sv
tb/sv/tb_link_error_recovery_policy_unit.sv
